// ===== rtl/core/fptm_pkg.sv =====
// Package for the frame phase timing monitor: widths, constants, codes and helpers.
package fptm_pkg;

    // Window geometry. WINDOW_SIZE must be a power of two; the ring index wraps on its own.
    localparam int WINDOW_SIZE   = 16;
    localparam int WIN_IDX_W     = $clog2(WINDOW_SIZE);
    localparam int FRACTION_BITS = 8;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int STAMP_W  = 32;
    localparam int MS_W     = 16;
    localparam int AVG_W    = 24;
    localparam int RAW_W    = 18;
    localparam int FAVG_W   = 26;
    localparam int DELAY_W  = 10;
    localparam int FPS_W    = 26;
    localparam int TARGET_W = 10;

    localparam longint MS_MAX_VAL = 65535;
    localparam int TOTAL_W  = $clog2(WINDOW_SIZE * MS_MAX_VAL + 1);

    localparam logic [MS_W-1:0]     MS_MAX      = '1;
    localparam logic [AVG_W-1:0]    AVG_MAX     = '1;
    localparam logic [FAVG_W-1:0]   FAVG_MAX    = '1;
    localparam logic [FPS_W-1:0]    FPS_MAX     = '1;

    // Reset contents of the rings and the target register.
    localparam logic [MS_W-1:0]     DRAW_INIT   = MS_W'(7);
    localparam logic [MS_W-1:0]     FRAME_INIT  = MS_W'(16);
    localparam logic [TARGET_W-1:0] TARGET_INIT = TARGET_W'(16);
    localparam logic [TOTAL_W-1:0]  DRAW_TOTAL_INIT  = TOTAL_W'(7 * WINDOW_SIZE);
    localparam logic [TOTAL_W-1:0]  FRAME_TOTAL_INIT = TOTAL_W'(16 * WINDOW_SIZE);

    // Frame rate numerator: 1000 ms per second times the window, in fixed point.
    localparam longint MS_PER_S  = 1000;
    localparam longint FPS_NUM   = (MS_PER_S * WINDOW_SIZE) * (longint'(1) << FRACTION_BITS);
    localparam int     FPS_NUM_W = $clog2(FPS_NUM + 1);
    localparam logic [FPS_NUM_W-1:0] FPS_NUM_VEC = FPS_NUM_W'(FPS_NUM);
    localparam int     DIV_CNT_W = $clog2(FPS_NUM_W);
    localparam int     FPS_CMP_W = (FPS_NUM_W > FPS_W) ? FPS_NUM_W : FPS_W;

    // Average arithmetic widths.
    localparam int AVG_FULL_W = TOTAL_W + FRACTION_BITS;
    localparam int AVG_CMP_W  = (AVG_FULL_W > AVG_W) ? AVG_FULL_W : AVG_W;
    localparam int FSUM_W     = AVG_W + 2;
    localparam int FSUM_CMP_W = (FSUM_W > FAVG_W) ? FSUM_W : FAVG_W;

    typedef logic [MS_W-1:0]    ms_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [AVG_W-1:0]   avg_t;

    typedef enum logic [OP_W-1:0] {
        OP_HANDLE = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DRAW   = 2'd2,
        OP_FRAME  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_UPDATE,
        ST_RESULT,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Window average: total scaled by the fraction bits, divided by the window, saturated.
    function automatic avg_t avg_of(input total_t total);
        logic [AVG_FULL_W-1:0] full;
        logic [AVG_CMP_W-1:0]  wide;
        full = AVG_FULL_W'(total) << FRACTION_BITS;
        wide = AVG_CMP_W'(full >> WIN_IDX_W);
        return (wide > AVG_CMP_W'(AVG_MAX)) ? AVG_MAX : AVG_W'(wide);
    endfunction

endpackage

// ===== rtl/core/frame_phase_timing_monitor.sv =====
// Top level of the frame phase timing monitor with its sequencer and frame rate divider.
//
//  Channel  | Beat signals            | Payload
//  ---------+-------------------------+----------------------------------------------
//  input    | in_valid / in_stall     | opcode, stamp_ms
//  output   | out_valid / out_stall   | phase_ms, phase_avg, frame_raw_ms, frame_avg,
//           |                         | delay_ms, fps
//  config   | cfg_valid / cfg_ready   | target_frame_ms
//
// A handle, update or draw beat steps through the diff, update, result and finish states after it
// is accepted; a frame end beat adds one divider step per quotient bit (22 steps) before finish.
// The result is loaded into the output register from finish; then the block can take a new beat.
// The frame rate is formed by a restoring divider, one quotient bit per cycle.
// Reset is asynchronous and active low; the rings come back to their initial contents at once.
// The input stalls while a beat is in work and while a finished result waits for a full output.
// The output register lets a result sit stalled while the next input beat is accepted.
module frame_phase_timing_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fptm_pkg::OP_W-1:0]     opcode,
    input  logic [fptm_pkg::STAMP_W-1:0]  stamp_ms,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fptm_pkg::MS_W-1:0]     phase_ms,
    output logic [fptm_pkg::AVG_W-1:0]    phase_avg,
    output logic [fptm_pkg::RAW_W-1:0]    frame_raw_ms,
    output logic [fptm_pkg::FAVG_W-1:0]   frame_avg,
    output logic [fptm_pkg::DELAY_W-1:0]  delay_ms,
    output logic [fptm_pkg::FPS_W-1:0]    fps,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fptm_pkg::TARGET_W-1:0] target_frame_ms
);

    // Sequencer state and the handshake decode that comes from it.
    fptm_pkg::state_t state_reg, state_next;
    logic in_fire;
    logic out_load;
    logic div_last;

    // Timing state.
    logic [fptm_pkg::TARGET_W-1:0]  target_reg;
    logic [fptm_pkg::STAMP_W-1:0]   frame_stamp_reg;
    logic [fptm_pkg::STAMP_W-1:0]   handle_stamp_reg;
    logic [fptm_pkg::STAMP_W-1:0]   update_stamp_reg;
    logic [fptm_pkg::WIN_IDX_W-1:0] win_idx_reg;
    fptm_pkg::ms_t                  handle_ring_reg [fptm_pkg::WINDOW_SIZE];
    fptm_pkg::ms_t                  update_ring_reg [fptm_pkg::WINDOW_SIZE];
    fptm_pkg::ms_t                  draw_ring_reg   [fptm_pkg::WINDOW_SIZE];
    fptm_pkg::ms_t                  frame_ring_reg  [fptm_pkg::WINDOW_SIZE];
    fptm_pkg::total_t               totals_reg      [4];
    fptm_pkg::ms_t                  last_handle_reg;
    fptm_pkg::ms_t                  last_update_reg;

    // Per-beat working registers.
    fptm_pkg::op_t                  op_reg;
    logic [fptm_pkg::STAMP_W-1:0]   stamp_reg;
    fptm_pkg::ms_t                  d_reg;
    fptm_pkg::ms_t                  old_reg;
    logic [fptm_pkg::RAW_W-1:0]     raw_reg;
    fptm_pkg::avg_t                 pavg_reg;
    logic [fptm_pkg::FAVG_W-1:0]    favg_reg;
    logic [fptm_pkg::DELAY_W-1:0]   delay_reg;
    fptm_pkg::total_t               den_reg;
    fptm_pkg::total_t               rem_reg;
    logic [fptm_pkg::FPS_NUM_W-1:0] quo_reg;
    logic [fptm_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Output register.
    logic                           out_valid_reg;
    fptm_pkg::ms_t                  phase_ms_reg;
    fptm_pkg::avg_t                 phase_avg_reg;
    logic [fptm_pkg::RAW_W-1:0]     frame_raw_ms_reg;
    logic [fptm_pkg::FAVG_W-1:0]    frame_avg_reg;
    logic [fptm_pkg::DELAY_W-1:0]   delay_ms_reg;
    logic [fptm_pkg::FPS_W-1:0]     fps_reg;

    // Datapath intermediates.
    logic [fptm_pkg::STAMP_W-1:0]   ref_stamp;
    logic [fptm_pkg::STAMP_W-1:0]   stamp_diff;
    fptm_pkg::ms_t                  ring_old;
    fptm_pkg::total_t               op_total;
    fptm_pkg::total_t               new_total;
    fptm_pkg::avg_t                 avg_handle;
    fptm_pkg::avg_t                 avg_update;
    fptm_pkg::avg_t                 avg_draw;
    logic [fptm_pkg::FSUM_CMP_W-1:0] favg_sum;
    logic [fptm_pkg::TOTAL_W:0]     div_partial;
    logic [fptm_pkg::TOTAL_W:0]     div_trial;
    logic [fptm_pkg::FPS_CMP_W-1:0] fps_wide;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fptm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = fptm_pkg::ST_DIFF;
                end
            end
            fptm_pkg::ST_DIFF:   state_next = fptm_pkg::ST_UPDATE;
            fptm_pkg::ST_UPDATE: state_next = fptm_pkg::ST_RESULT;
            fptm_pkg::ST_RESULT:
            begin
                if (op_reg == fptm_pkg::OP_FRAME)
                begin
                    state_next = fptm_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = fptm_pkg::ST_FINISH;
                end
            end
            fptm_pkg::ST_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = fptm_pkg::ST_FINISH;
                end
            end
            fptm_pkg::ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = fptm_pkg::ST_IDLE;
                end
            end
            default: state_next = fptm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and strobes.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall  = (state_reg != fptm_pkg::ST_IDLE);
        cfg_ready = 1'b1;
        in_fire   = in_valid && (state_reg == fptm_pkg::ST_IDLE);
        // The finished result moves into the output register once that register is free.
        out_load  = (state_reg == fptm_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);
        div_last  = (state_reg == fptm_pkg::ST_DIVIDE) && (div_cnt_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fptm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Combinational datapath pieces.
    // ------------------------------------------------------------------
    always_comb
    begin
        // Each phase is measured from the end of the phase before it; handle and frame
        // end both measure from the previous frame end.
        case (op_reg)
            fptm_pkg::OP_UPDATE: ref_stamp = handle_stamp_reg;
            fptm_pkg::OP_DRAW:   ref_stamp = update_stamp_reg;
            default:             ref_stamp = frame_stamp_reg;
        endcase
        stamp_diff = stamp_reg - ref_stamp;

        case (op_reg)
            fptm_pkg::OP_HANDLE: ring_old = handle_ring_reg[win_idx_reg];
            fptm_pkg::OP_UPDATE: ring_old = update_ring_reg[win_idx_reg];
            fptm_pkg::OP_DRAW:   ring_old = draw_ring_reg[win_idx_reg];
            default:             ring_old = frame_ring_reg[win_idx_reg];
        endcase

        op_total  = totals_reg[op_reg];
        new_total = op_total - fptm_pkg::TOTAL_W'(old_reg) + fptm_pkg::TOTAL_W'(d_reg);

        avg_handle = fptm_pkg::avg_of(totals_reg[fptm_pkg::OP_HANDLE]);
        avg_update = fptm_pkg::avg_of(totals_reg[fptm_pkg::OP_UPDATE]);
        avg_draw   = fptm_pkg::avg_of(totals_reg[fptm_pkg::OP_DRAW]);
        favg_sum   = fptm_pkg::FSUM_CMP_W'(avg_handle) + fptm_pkg::FSUM_CMP_W'(avg_update)
                   + fptm_pkg::FSUM_CMP_W'(avg_draw);

        // One restoring division step: bring down the next numerator bit and try the divisor.
        div_partial = {rem_reg, fptm_pkg::FPS_NUM_VEC[div_cnt_reg]};
        div_trial   = div_partial - {1'b0, den_reg};

        fps_wide = fptm_pkg::FPS_CMP_W'(quo_reg);
    end

    // ------------------------------------------------------------------
    // Timing state with reset values.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg       <= fptm_pkg::TARGET_INIT;
            frame_stamp_reg  <= '0;
            handle_stamp_reg <= '0;
            update_stamp_reg <= '0;
            win_idx_reg      <= '0;
            for (int i = 0; i < fptm_pkg::WINDOW_SIZE; i++)
            begin
                handle_ring_reg[i] <= '0;
                update_ring_reg[i] <= '0;
                draw_ring_reg[i]   <= fptm_pkg::DRAW_INIT;
                frame_ring_reg[i]  <= fptm_pkg::FRAME_INIT;
            end
            totals_reg[fptm_pkg::OP_HANDLE] <= '0;
            totals_reg[fptm_pkg::OP_UPDATE] <= '0;
            totals_reg[fptm_pkg::OP_DRAW]   <= fptm_pkg::DRAW_TOTAL_INIT;
            totals_reg[fptm_pkg::OP_FRAME]  <= fptm_pkg::FRAME_TOTAL_INIT;
            last_handle_reg  <= '0;
            last_update_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= target_frame_ms;
            end
            if (state_reg == fptm_pkg::ST_UPDATE)
            begin
                totals_reg[op_reg] <= new_total;
                case (op_reg)
                    fptm_pkg::OP_HANDLE:
                    begin
                        handle_ring_reg[win_idx_reg] <= d_reg;
                        handle_stamp_reg             <= stamp_reg;
                        last_handle_reg              <= d_reg;
                    end
                    fptm_pkg::OP_UPDATE:
                    begin
                        update_ring_reg[win_idx_reg] <= d_reg;
                        update_stamp_reg             <= stamp_reg;
                        last_update_reg              <= d_reg;
                    end
                    fptm_pkg::OP_DRAW:
                    begin
                        draw_ring_reg[win_idx_reg] <= d_reg;
                    end
                    default:
                    begin
                        // Frame end closes the window slot that all four rings share.
                        frame_ring_reg[win_idx_reg] <= d_reg;
                        frame_stamp_reg             <= stamp_reg;
                        win_idx_reg                 <= win_idx_reg + 1'b1;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-beat working registers and the frame rate divider.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fptm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_reg    <= fptm_pkg::op_t'(opcode);
                    stamp_reg <= stamp_ms;
                end
            end
            fptm_pkg::ST_DIFF:
            begin
                d_reg   <= (stamp_diff > fptm_pkg::STAMP_W'(fptm_pkg::MS_MAX))
                         ? fptm_pkg::MS_MAX : stamp_diff[fptm_pkg::MS_W-1:0];
                old_reg <= ring_old;
            end
            fptm_pkg::ST_UPDATE:
            begin
                raw_reg <= fptm_pkg::RAW_W'(last_handle_reg) + fptm_pkg::RAW_W'(last_update_reg)
                         + fptm_pkg::RAW_W'(d_reg);
            end
            fptm_pkg::ST_RESULT:
            begin
                pavg_reg  <= fptm_pkg::avg_of(op_total);
                favg_reg  <= (favg_sum > fptm_pkg::FSUM_CMP_W'(fptm_pkg::FAVG_MAX))
                           ? fptm_pkg::FAVG_MAX : fptm_pkg::FAVG_W'(favg_sum);
                delay_reg <= (fptm_pkg::RAW_W'(target_reg) > raw_reg)
                           ? fptm_pkg::DELAY_W'(fptm_pkg::RAW_W'(target_reg) - raw_reg) : '0;
                // An empty frame window divides as if it held one millisecond.
                den_reg     <= (op_total == '0) ? fptm_pkg::TOTAL_W'(1) : op_total;
                rem_reg     <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= fptm_pkg::DIV_CNT_W'(fptm_pkg::FPS_NUM_W - 1);
            end
            fptm_pkg::ST_DIVIDE:
            begin
                if (!div_trial[fptm_pkg::TOTAL_W])
                begin
                    rem_reg <= div_trial[fptm_pkg::TOTAL_W-1:0];
                    quo_reg <= {quo_reg[fptm_pkg::FPS_NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_partial[fptm_pkg::TOTAL_W-1:0];
                    quo_reg <= {quo_reg[fptm_pkg::FPS_NUM_W-2:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. Fields that do not apply to an event are zero.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            phase_ms_reg  <= d_reg;
            phase_avg_reg <= pavg_reg;
            if (op_reg == fptm_pkg::OP_DRAW)
            begin
                frame_raw_ms_reg <= raw_reg;
                frame_avg_reg    <= favg_reg;
                delay_ms_reg     <= delay_reg;
            end
            else
            begin
                frame_raw_ms_reg <= '0;
                frame_avg_reg    <= '0;
                delay_ms_reg     <= '0;
            end
            if (op_reg == fptm_pkg::OP_FRAME)
            begin
                fps_reg <= (fps_wide > fptm_pkg::FPS_CMP_W'(fptm_pkg::FPS_MAX))
                         ? fptm_pkg::FPS_MAX : fptm_pkg::FPS_W'(fps_wide);
            end
            else
            begin
                fps_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign phase_ms     = phase_ms_reg;
    assign phase_avg    = phase_avg_reg;
    assign frame_raw_ms = frame_raw_ms_reg;
    assign frame_avg    = frame_avg_reg;
    assign delay_ms     = delay_ms_reg;
    assign fps          = fps_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // An accepted input beat starts the sequence in the next cycle.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == fptm_pkg::ST_DIFF))
        else $error("accepted beat did not start the sequence");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fptm_pkg::ST_DIVIDE) |-> (den_reg != '0))
        else $error("divider running with a zero divisor");

    // The shared window index moves only after a frame end has updated the rings.
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (win_idx_reg != $past(win_idx_reg)) |->
        ($past(state_reg) == fptm_pkg::ST_UPDATE && $past(op_reg) == fptm_pkg::OP_FRAME))
        else $error("window index moved outside a frame end update");

    // A result appears only from the finishing step of the sequence.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == fptm_pkg::ST_FINISH))
        else $error("result appeared outside the finishing step");

endmodule

// ===== tb/sv/fptm_timing_checker.sv =====
// Checker that predicts and compares every result beat of the frame phase timing monitor.
module fptm_timing_checker
    import fptm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [STAMP_W-1:0]  stamp_ms,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [MS_W-1:0]     phase_ms,
    input  logic [AVG_W-1:0]    phase_avg,
    input  logic [RAW_W-1:0]    frame_raw_ms,
    input  logic [FAVG_W-1:0]   frame_avg,
    input  logic [DELAY_W-1:0]  delay_ms,
    input  logic [FPS_W-1:0]    fps,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [TARGET_W-1:0] target_frame_ms,
    output int unsigned         fail_count,
    output int unsigned         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MS_W-1:0]    ms;
        logic [AVG_W-1:0]   avg;
        logic [RAW_W-1:0]   raw;
        logic [FAVG_W-1:0]  favg;
        logic [DELAY_W-1:0] delay;
        logic [FPS_W-1:0]   fps;
    } timing_result_t;

    // Shadow copy of the monitor state; the rings are indexed by opcode.
    logic [TARGET_W-1:0] target_shadow;
    logic [STAMP_W-1:0]  frame_mark;
    logic [STAMP_W-1:0]  handle_mark;
    logic [STAMP_W-1:0]  update_mark;
    int unsigned         window_pos;
    ms_t                 rings [4][WINDOW_SIZE];
    int unsigned         totals [4];
    int unsigned         last_handle_dur;
    int unsigned         last_update_dur;
    timing_result_t      timing_fifo [$];
    int unsigned         beats_checked;

    function automatic int unsigned window_avg(input int unsigned total);
        longint scaled;
        scaled = (longint'(total) * (longint'(1) << FRACTION_BITS)) / WINDOW_SIZE;
        return (scaled > longint'(AVG_MAX)) ? int'(AVG_MAX) : int'(scaled);
    endfunction

    function automatic timing_result_t predict_timing(input op_t op,
                                                      input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] since;
        int unsigned        dur;
        int unsigned        raw;
        longint             favg_sum;
        longint             rate;
        longint             den;
        timing_result_t     r;
        r = '0;
        case (op)
            OP_HANDLE: since = stamp - frame_mark;
            OP_UPDATE: since = stamp - handle_mark;
            OP_DRAW:   since = stamp - update_mark;
            default:   since = stamp - frame_mark;
        endcase
        dur = (since > STAMP_W'(MS_MAX)) ? int'(MS_MAX) : int'(since);
        totals[int'(op)] = totals[int'(op)] - rings[int'(op)][window_pos] + dur;
        rings[int'(op)][window_pos] = MS_W'(dur);
        r.ms  = MS_W'(dur);
        r.avg = AVG_W'(window_avg(totals[int'(op)]));
        case (op)
            OP_HANDLE:
            begin
                handle_mark     = stamp;
                last_handle_dur = dur;
            end
            OP_UPDATE:
            begin
                update_mark     = stamp;
                last_update_dur = dur;
            end
            OP_DRAW:
            begin
                raw      = last_handle_dur + last_update_dur + dur;
                favg_sum = longint'(window_avg(totals[int'(OP_HANDLE)]))
                         + longint'(window_avg(totals[int'(OP_UPDATE)]))
                         + longint'(window_avg(totals[int'(OP_DRAW)]));
                r.raw    = RAW_W'(raw);
                r.favg   = (favg_sum > longint'(FAVG_MAX)) ? FAVG_MAX : FAVG_W'(favg_sum);
                r.delay  = (int'(target_shadow) > raw) ?
                           DELAY_W'(int'(target_shadow) - raw) : '0;
            end
            default:
            begin
                window_pos = (window_pos + 1) % WINDOW_SIZE;
                frame_mark = stamp;
                den        = (totals[int'(OP_FRAME)] == 0) ? 1 : totals[int'(OP_FRAME)];
                rate       = ((MS_PER_S * WINDOW_SIZE) * (longint'(1) << FRACTION_BITS)) / den;
                r.fps      = (rate > longint'(FPS_MAX)) ? FPS_MAX : FPS_W'(rate);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 100)
            $display("%0t: %0s mismatch on result beat %0d: got %0d, expected %0d",
                     $realtime, what, beats_checked, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        timing_result_t want;
        if (!rst_n)
        begin
            target_shadow   = TARGET_INIT;
            frame_mark      = '0;
            handle_mark     = '0;
            update_mark     = '0;
            window_pos      = 0;
            last_handle_dur = 0;
            last_update_dur = 0;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                rings[int'(OP_HANDLE)][i] = '0;
                rings[int'(OP_UPDATE)][i] = '0;
                rings[int'(OP_DRAW)][i]   = DRAW_INIT;
                rings[int'(OP_FRAME)][i]  = FRAME_INIT;
            end
            totals[int'(OP_HANDLE)] = 0;
            totals[int'(OP_UPDATE)] = 0;
            totals[int'(OP_DRAW)]   = int'(DRAW_INIT) * WINDOW_SIZE;
            totals[int'(OP_FRAME)]  = int'(FRAME_INIT) * WINDOW_SIZE;
            timing_fifo.delete();
            beats_checked = 0;
            fail_count    = 0;
            pending       = 0;
        end
        else
        begin
            // A result beat always belongs to an earlier input beat, so check it first.
            if (out_valid && !out_stall)
            begin
                if (timing_fifo.size() == 0)
                    report_mismatch("unexpected result beat", phase_ms, 0);
                else
                begin
                    want = timing_fifo.pop_front();
                    if (phase_ms !== want.ms)
                        report_mismatch("phase_ms", phase_ms, want.ms);
                    if (phase_avg !== want.avg)
                        report_mismatch("phase_avg", phase_avg, want.avg);
                    if (frame_raw_ms !== want.raw)
                        report_mismatch("frame_raw_ms", frame_raw_ms, want.raw);
                    if (frame_avg !== want.favg)
                        report_mismatch("frame_avg", frame_avg, want.favg);
                    if (delay_ms !== want.delay)
                        report_mismatch("delay_ms", delay_ms, want.delay);
                    if (fps !== want.fps)
                        report_mismatch("fps", fps, want.fps);
                end
                beats_checked++;
            end
            if (in_valid && !in_stall)
                timing_fifo.push_back(predict_timing(op_t'(opcode), stamp_ms));
            if (cfg_valid && cfg_ready)
                target_shadow = target_frame_ms;
            pending = timing_fifo.size();
        end
    end

endmodule

// ===== tb/sv/tb_frame_phase_timing_monitor.sv =====
// Testbench top for the frame phase timing monitor: clock, reset, stimulus and verdict.
module tb_frame_phase_timing_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import fptm_pkg::*;

    // The slowest beat is a frame end, which runs the divider; each beat may also see a
    // gap on the sender and a stall burst on the receiver. Roughly 550 beats, plus one
    // long hold, fit within the cycle limit many times over.
    localparam int unsigned CYCLE_LIMIT      = 200000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 40;
    localparam int unsigned PHASE_BEATS      = 100;

    logic                clk             = 1'b0;
    logic                rst_n           = 1'b0;
    logic                in_valid        = 1'b0;
    logic                in_stall;
    logic [OP_W-1:0]     opcode          = '0;
    logic [STAMP_W-1:0]  stamp_ms        = '0;
    logic                out_valid;
    logic                out_stall       = 1'b0;
    logic [MS_W-1:0]     phase_ms;
    logic [AVG_W-1:0]    phase_avg;
    logic [RAW_W-1:0]    frame_raw_ms;
    logic [FAVG_W-1:0]   frame_avg;
    logic [DELAY_W-1:0]  delay_ms;
    logic [FPS_W-1:0]    fps;
    logic                cfg_valid       = 1'b0;
    logic                cfg_ready;
    logic [TARGET_W-1:0] target_frame_ms = TARGET_INIT;

    int unsigned         fail_count;
    int unsigned         pending;
    int unsigned         cycle_count     = 0;

    // Idling is switched off for the last phase, so back-to-back beats are covered too.
    logic                idle_on         = 1'b1;
    // Raised by the stimulus to ask the stall process for one long hold-off.
    logic                hold_off_req    = 1'b0;
    // Running millisecond tick for well-formed frames.
    logic [STAMP_W-1:0]  tick_now        = '0;

    frame_phase_timing_monitor u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .stamp_ms        (stamp_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase_ms        (phase_ms),
        .phase_avg       (phase_avg),
        .frame_raw_ms    (frame_raw_ms),
        .frame_avg       (frame_avg),
        .delay_ms        (delay_ms),
        .fps             (fps),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .target_frame_ms (target_frame_ms)
    );

    fptm_timing_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .stamp_ms        (stamp_ms),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .phase_ms        (phase_ms),
        .phase_avg       (phase_avg),
        .frame_raw_ms    (frame_raw_ms),
        .frame_avg       (frame_avg),
        .delay_ms        (delay_ms),
        .fps             (fps),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .target_frame_ms (target_frame_ms),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The watchdog ends a run that hangs on a handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver side. Stall bursts of random length fall at random points, so they hit
    // every stage of the sequencer. On request one long hold-off runs here, counted in
    // this process, while the sender keeps offering beats and the block backs up.
    initial
    begin : out_stall_gen
        int unsigned burst;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_stall    = 1'b0;
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                burst     = $urandom_range(1, 14);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Offers one event beat. It is entered at a falling edge and returns at the falling
    // edge after the beat was taken, with valid still high so that a following beat can
    // go out back to back without valid dropping in between.
    task automatic send_event(input op_t op, input logic [STAMP_W-1:0] stamp);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap      = $urandom_range(1, 14);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        opcode   = op;
        stamp_ms = stamp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Waits until every predicted result has been taken, then a few more cycles.
    task automatic wait_drained(input int unsigned extra);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // The target register is only written while the block is idle.
    task automatic write_target(input logic [TARGET_W-1:0] value);
        wait_drained(4);
        cfg_valid       = 1'b1;
        target_frame_ms = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly short phases, now and then a jump that saturates or wraps the difference.
    function automatic logic [STAMP_W-1:0] stamp_advance();
        case ($urandom_range(0, 19))
            0:       return $urandom;
            1, 2:    return $urandom_range(0, 70000);
            3:       return '0;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // Random phase: mostly complete handle, update, draw, frame-end sequences with random
    // spacing; some frames lose one event, and some beats are pure noise.
    task automatic run_random_phase(input int unsigned beats);
        int unsigned sent;
        int unsigned skip;
        int unsigned pick;
        sent = 0;
        while (sent < beats)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_event(op_t'($urandom_range(0, 3)), $urandom);
                sent++;
            end
            else
            begin
                skip = (pick == 1) ? $urandom_range(0, 3) : 4;
                for (int k = 0; k < 4; k++)
                begin
                    if (k != skip)
                    begin
                        tick_now = tick_now + stamp_advance();
                        send_event(op_t'(k), tick_now);
                        sent++;
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset target of 16 ms.
        // Sixteen frame ends at the reset stamp fill the frame ring with zero durations,
        // so the last of them sees a zero frame total and the rate is formed as for one.
        for (int i = 0; i < WINDOW_SIZE; i++)
            send_event(OP_FRAME, '0);
        // A handle end far ahead saturates at 65535 ms; the update end then wraps past
        // the top of the tick counter, and the draw end has a zero duration.
        send_event(OP_HANDLE, 32'hFFFF_FFF0);
        send_event(OP_UPDATE, 32'h0000_0010);
        send_event(OP_DRAW,   32'h0000_0010);
        // A short frame under the target gives a positive limiter delay.
        send_event(OP_FRAME,  32'd100);
        send_event(OP_HANDLE, 32'd101);
        send_event(OP_UPDATE, 32'd103);
        send_event(OP_DRAW,   32'd106);
        // Frame end at the largest stamp saturates the frame duration.
        send_event(OP_FRAME,  32'hFFFF_FFFF);

        tick_now = $urandom;

        // A target of 1000 ms; the receiver also holds off for a long stretch here.
        write_target(TARGET_W'(1000));
        hold_off_req = 1'b1;
        run_random_phase(PHASE_BEATS);

        // Smallest nonzero target.
        write_target(TARGET_W'(1));
        run_random_phase(PHASE_BEATS);

        // A target of zero leaves no room for any delay.
        write_target('0);
        run_random_phase(PHASE_BEATS);

        // All ones in the register field.
        write_target('1);
        run_random_phase(PHASE_BEATS);

        // Some target in range, and no idling on either side to the end.
        write_target(TARGET_W'($urandom_range(1, 1000)));
        wait_drained(0);
        idle_on = 1'b0;
        run_random_phase(PHASE_BEATS);

        wait_drained(DRAIN_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
